### sv/vrp_pkg.sv
// Shared types, constants and sine table builder for the vertex rotate/project pipeline.
`default_nettype none
package vrp_pkg;

  localparam int COORD_W            = 16;
  localparam int FRAC_BITS          = 12;
  localparam int SINE_TABLE_ENTRIES = 1024;
  localparam int ANGLE_W            = 12;
  localparam int PHASE_W            = ANGLE_W - 2;
  localparam int SIN_W              = FRAC_BITS + 1;  // table magnitude, 0 .. 1.0
  localparam int TRIG_W             = FRAC_BITS + 2;  // signed sine / cosine
  localparam int IDX_W              = $clog2(SINE_TABLE_ENTRIES + 1);
  localparam int SCALE_W            = IDX_W + PHASE_W;

  // rotated coordinates stay below 2^17 in magnitude after three rotations
  localparam int ROT_W  = 19;
  localparam int PROD_W = ROT_W + TRIG_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int D_W    = ROT_W + 1;

  localparam int DIST_W     = 15;
  localparam int FOCAL_W    = 8;
  localparam int CENTER_W   = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 15;

  // projection divide: numerator below 2^29 in magnitude, divisor up to 2^18
  localparam int DPOS_W     = 18;
  localparam int DEN_W      = DPOS_W + 1;
  localparam int NUM_W      = 30;
  localparam int MAG_W      = NUM_W - 1;
  localparam int QUOT_W     = COORD_W + 1;
  localparam int STEP_BITS  = 2;
  localparam int DIV_STEPS  = (QUOT_W + STEP_BITS - 1) / STEP_BITS;
  localparam int DIV_STAGES = DIV_STEPS + 2;
  localparam int CMP_W      = DEN_W + QUOT_W;

  localparam int ROT_STAGES  = 3;
  localparam int PREP_STAGE  = ROT_STAGES;
  localparam int PIPE_STAGES = ROT_STAGES + 1 + DIV_STAGES;

  localparam logic [QUOT_W-1:0] POS_LIMIT = QUOT_W'((1 << (COORD_W - 1)) - 1);
  localparam logic [QUOT_W-1:0] NEG_LIMIT = QUOT_W'(1 << (COORD_W - 1));
  localparam logic signed [COORD_W-1:0] OUT_MAX = COORD_W'((1 << (COORD_W - 1)) - 1);
  localparam logic signed [COORD_W-1:0] OUT_MIN = COORD_W'(1 << (COORD_W - 1));

  localparam logic [DIST_W-1:0]   DIST_RESET  = DIST_W'(20480);
  localparam logic [FOCAL_W-1:0]  FOCAL_RESET = FOCAL_W'(24);
  localparam logic [CENTER_W-1:0] CX_RESET    = CENTER_W'(40);
  localparam logic [CENTER_W-1:0] CY_RESET    = CENTER_W'(20);

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ANGLE_X       = 3'd0,
    REG_ANGLE_Y       = 3'd1,
    REG_ANGLE_Z       = 3'd2,
    REG_VIEW_DISTANCE = 3'd3,
    REG_FOCAL_SCALE   = 3'd4,
    REG_CENTER_X      = 3'd5,
    REG_CENTER_Y      = 3'd6
  } cfg_reg_t;

  typedef enum logic [1:0] {
    AXIS_X,
    AXIS_Y,
    AXIS_Z
  } axis_t;

  typedef enum logic [1:0] {
    TRIG_IDLE,
    TRIG_SIN,
    TRIG_COS,
    TRIG_LAST
  } trig_state_t;

  typedef struct packed {
    logic               start;
    axis_t              axis;
    logic [ANGLE_W-1:0] angle;
  } trig_req_t;

  typedef struct packed {
    logic signed [TRIG_W-1:0] sin_x;
    logic signed [TRIG_W-1:0] cos_x;
    logic signed [TRIG_W-1:0] sin_y;
    logic signed [TRIG_W-1:0] cos_y;
    logic signed [TRIG_W-1:0] sin_z;
    logic signed [TRIG_W-1:0] cos_z;
  } trig_t;

  typedef logic [SIN_W-1:0] sine_rom_t [0:SINE_TABLE_ENTRIES];

  // long division for the series terms; only evaluated while the table is built
  function automatic longint unsigned div_u64(input longint unsigned n,
                                              input longint unsigned d);
    longint unsigned q;
    longint unsigned rem;
    q   = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], n[b]};
      if (rem >= d) begin
        rem  = rem - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // sin(idx * pi / 2N) by an eight-term series in Q30, rounded to FRAC_BITS
  function automatic logic [SIN_W-1:0] rom_entry(input longint unsigned idx);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned r;
    longint unsigned one;
    longint          sum;
    x    = idx * HALF_PI_Q30 / SINE_TABLE_ENTRIES;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    one  = 64'd1 << FRAC_BITS;
    for (int k = 1; k <= 7; k++) begin
      term = (term * x2) >> 30;
      term = div_u64(term, 64'((2 * k) * (2 * k + 1)));
      if ((k % 2) == 1) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    r = (longint'(sum) + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
    if (r > one) r = one;
    return SIN_W'(r);
  endfunction

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    for (int i = 0; i <= SINE_TABLE_ENTRIES; i++) begin
      rom[i] = rom_entry(longint'(i));
    end
    return rom;
  endfunction

endpackage
`default_nettype wire

### sv/vertex_rotate_project.sv
// Fifteen-stage pipeline: rotation, projection setup, then divide (sign/overflow, nine two-bit
// steps, saturation). Throughput: one vertex a cycle while the output is not stalled and no angle
// refresh is under way; a stalled output only backs up as far as the first bubble.
// An angle write refreshes that axis's sine/cosine from the table, inputs held off meanwhile.
// Reset (synchronous): pipeline empty, angles 0, distance 5.0, focal 24, centre (40, 20).
`default_nettype none
module vertex_rotate_project import vrp_pkg::*; (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic signed [COORD_W-1:0] vertex_x,
  input  wire logic signed [COORD_W-1:0] vertex_y,
  input  wire logic signed [COORD_W-1:0] vertex_z,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic signed [COORD_W-1:0]      screen_x,
  output logic signed [COORD_W-1:0]      screen_y,
  output logic                           behind_viewer,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [CFG_DATA_W-1:0]     cfg_data
);

  logic [DIST_W-1:0]   view_distance;
  logic [FOCAL_W-1:0]  focal_scale;
  logic [CENTER_W-1:0] center_x;
  logic [CENTER_W-1:0] center_y;

  logic [PIPE_STAGES-1:0] v;
  logic [PIPE_STAGES-1:0] en;
  logic                   in_fire;
  logic                   cfg_fire;

  trig_req_t trig_req;
  trig_t     trig;
  logic      trig_busy;

  logic signed [ROT_W-1:0] rot_x, rot_y, rot_z;

  logic signed [D_W-1:0]   d_w;
  logic                    behind_w;
  logic [DPOS_W-1:0]       d_pos;
  logic [NUM_W-1:0]        cx_term, cy_term;
  logic signed [NUM_W-1:0] x_term, y_term;
  logic signed [NUM_W-1:0] num_x, num_y;
  logic [DEN_W-1:0]        den_x, den_y;
  logic                    behind_q [0:DIV_STAGES];
  logic signed [COORD_W-1:0] quot_x, quot_y;

  // a stage moves on when it is empty or its successor moves on
  assign en[PIPE_STAGES-1] = !v[PIPE_STAGES-1] || out_ready;
  for (genvar k = 0; k < PIPE_STAGES - 1; k++) begin : g_en
    assign en[k] = !v[k] || en[k+1];
  end

  assign in_ready  = en[0] && !trig_busy;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = !trig_busy;
  assign cfg_fire  = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= in_fire;
      for (int k = 1; k < PIPE_STAGES; k++) begin
        if (en[k]) v[k] <= v[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      view_distance <= DIST_RESET;
      focal_scale   <= FOCAL_RESET;
      center_x      <= CX_RESET;
      center_y      <= CY_RESET;
    end else if (cfg_fire) begin
      case (cfg_reg_t'(cfg_index))
        REG_VIEW_DISTANCE: view_distance <= cfg_data[DIST_W-1:0];
        REG_FOCAL_SCALE:   focal_scale   <= cfg_data[FOCAL_W-1:0];
        REG_CENTER_X:      center_x      <= cfg_data[CENTER_W-1:0];
        REG_CENTER_Y:      center_y      <= cfg_data[CENTER_W-1:0];
        default: ;
      endcase
    end
  end

  // angles live only as their sine/cosine in the trig block
  always_comb begin
    trig_req.start = 1'b0;
    trig_req.axis  = AXIS_X;
    trig_req.angle = cfg_data[ANGLE_W-1:0];
    if (cfg_fire) begin
      case (cfg_reg_t'(cfg_index))
        REG_ANGLE_X: trig_req.start = 1'b1;
        REG_ANGLE_Y: begin
          trig_req.start = 1'b1;
          trig_req.axis  = AXIS_Y;
        end
        REG_ANGLE_Z: begin
          trig_req.start = 1'b1;
          trig_req.axis  = AXIS_Z;
        end
        default: ;
      endcase
    end
  end

  vrp_trig u_trig (
    .clk  (clk),
    .rst  (rst),
    .req  (trig_req),
    .busy (trig_busy),
    .trig (trig)
  );

  vrp_rotate u_rotate (
    .clk  (clk),
    .en   (en[ROT_STAGES-1:0]),
    .vx   (vertex_x),
    .vy   (vertex_y),
    .vz   (vertex_z),
    .trig (trig),
    .x3   (rot_x),
    .y3   (rot_y),
    .z2   (rot_z)
  );

  // projection setup: d = z + distance, behind flag, numerators and denominators of both divides
  assign d_w      = D_W'(rot_z) + D_W'({1'b0, view_distance});
  assign behind_w = d_w[D_W-1] || (d_w == '0);
  assign d_pos    = d_w[DPOS_W-1:0];
  assign cx_term  = NUM_W'(center_x) * NUM_W'(d_pos);
  assign cy_term  = NUM_W'(center_y) * NUM_W'({d_pos, 1'b0});
  assign x_term   = NUM_W'(rot_x) * $signed(NUM_W'(focal_scale));
  assign y_term   = NUM_W'(rot_y) * $signed(NUM_W'(focal_scale));

  always_ff @(posedge clk) begin
    if (en[PREP_STAGE]) begin
      num_x       <= $signed(cx_term) + x_term;
      num_y       <= $signed(cy_term) - y_term;
      den_x       <= DEN_W'(d_pos);
      den_y       <= {d_pos, 1'b0};
      behind_q[0] <= behind_w;
    end
    for (int k = 1; k <= DIV_STAGES; k++) begin
      if (en[PREP_STAGE + k]) behind_q[k] <= behind_q[k-1];
    end
  end

  vrp_divider u_div_x (
    .clk  (clk),
    .en   (en[PIPE_STAGES-1:PREP_STAGE+1]),
    .num  (num_x),
    .den  (den_x),
    .quot (quot_x)
  );

  vrp_divider u_div_y (
    .clk  (clk),
    .en   (en[PIPE_STAGES-1:PREP_STAGE+1]),
    .num  (num_y),
    .den  (den_y),
    .quot (quot_y)
  );

  assign out_valid     = v[PIPE_STAGES-1];
  assign behind_viewer = behind_q[DIV_STAGES];
  assign screen_x      = behind_q[DIV_STAGES] ? '0 : quot_x;
  assign screen_y      = behind_q[DIV_STAGES] ? '0 : quot_y;

endmodule
`default_nettype wire

### sv/vrp_trig.sv
// Sine/cosine register file, refreshed from the quarter-wave table after an angle write.
`default_nettype none
module vrp_trig import vrp_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire trig_req_t req,
  output logic           busy,
  output trig_t          trig
);

  localparam sine_rom_t SineRom = build_sine_rom();

  trig_state_t              state;
  trig_state_t              state_next;
  axis_t                    axis;
  logic [ANGLE_W-1:0]       angle;
  logic [ANGLE_W-1:0]       look_angle;
  logic [1:0]               quad;
  logic [PHASE_W-1:0]       phase;
  logic [SCALE_W-1:0]       scaled;
  logic [IDX_W-1:0]         idx_raw;
  logic [IDX_W-1:0]         idx;
  logic [SIN_W-1:0]         rom_data;
  logic                     rom_neg;
  logic signed [TRIG_W-1:0] rom_val;
  logic                     store_sin;
  logic                     store_cos;

  always_comb begin
    case (state)
      TRIG_IDLE: state_next = req.start ? TRIG_SIN : TRIG_IDLE;
      TRIG_SIN:  state_next = TRIG_COS;
      TRIG_COS:  state_next = TRIG_LAST;
      TRIG_LAST: state_next = TRIG_IDLE;
      default:   state_next = TRIG_IDLE;
    endcase
  end

  // table read issued in the state before its store
  always_comb begin
    busy       = 1'b1;
    look_angle = angle;
    store_sin  = 1'b0;
    store_cos  = 1'b0;
    case (state)
      TRIG_IDLE: busy = 1'b0;
      TRIG_SIN:  look_angle = angle;
      TRIG_COS: begin
        look_angle = angle + ANGLE_W'(1 << PHASE_W);
        store_sin  = 1'b1;
      end
      TRIG_LAST: store_cos = 1'b1;
      default:   busy = 1'b1;
    endcase
  end

  assign quad    = look_angle[ANGLE_W-1 -: 2];
  assign phase   = look_angle[PHASE_W-1:0];
  assign scaled  = SCALE_W'(phase) * SCALE_W'(SINE_TABLE_ENTRIES);
  assign idx_raw = IDX_W'(scaled >> PHASE_W);
  assign idx     = quad[0] ? IDX_W'(SINE_TABLE_ENTRIES) - idx_raw : idx_raw;
  assign rom_val = rom_neg ? TRIG_W'(0) - TRIG_W'(rom_data) : TRIG_W'(rom_data);

  always_ff @(posedge clk) begin
    rom_data <= SineRom[idx];
    rom_neg  <= quad[1];
    if (state == TRIG_IDLE && req.start) begin
      axis  <= req.axis;
      angle <= req.angle;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= TRIG_IDLE;
      trig.sin_x <= '0;
      trig.sin_y <= '0;
      trig.sin_z <= '0;
      trig.cos_x <= TRIG_W'(1 << FRAC_BITS);
      trig.cos_y <= TRIG_W'(1 << FRAC_BITS);
      trig.cos_z <= TRIG_W'(1 << FRAC_BITS);
    end else begin
      state <= state_next;
      if (store_sin) begin
        case (axis)
          AXIS_X:  trig.sin_x <= rom_val;
          AXIS_Y:  trig.sin_y <= rom_val;
          AXIS_Z:  trig.sin_z <= rom_val;
          default: ;
        endcase
      end
      if (store_cos) begin
        case (axis)
          AXIS_X:  trig.cos_x <= rom_val;
          AXIS_Y:  trig.cos_y <= rom_val;
          AXIS_Z:  trig.cos_z <= rom_val;
          default: ;
        endcase
      end
    end
  end

endmodule
`default_nettype wire

### sv/vrp_rotate.sv
// Three-stage rotation about X, then Y, then Z.
`default_nettype none
module vrp_rotate import vrp_pkg::*; (
  input  wire logic                      clk,
  input  wire logic [ROT_STAGES-1:0]     en,
  input  wire logic signed [COORD_W-1:0] vx,
  input  wire logic signed [COORD_W-1:0] vy,
  input  wire logic signed [COORD_W-1:0] vz,
  input  wire trig_t                     trig,
  output logic signed [ROT_W-1:0]        x3,
  output logic signed [ROT_W-1:0]        y3,
  output logic signed [ROT_W-1:0]        z2
);

  function automatic logic signed [SUM_W-1:0] mac2(
    input logic signed [ROT_W-1:0]  a,
    input logic signed [TRIG_W-1:0] ka,
    input logic signed [ROT_W-1:0]  b,
    input logic signed [TRIG_W-1:0] kb
  );
    logic signed [PROD_W-1:0] pa;
    logic signed [PROD_W-1:0] pb;
    pa = a * ka;
    pb = b * kb;
    return SUM_W'(pa) + SUM_W'(pb);
  endfunction

  // shift out the fraction, halves round up
  function automatic logic signed [ROT_W-1:0] rnd(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] w;
    w = v + SUM_W'(1 << (FRAC_BITS - 1));
    return w[FRAC_BITS +: ROT_W];
  endfunction

  logic signed [ROT_W-1:0] s1_x, s1_y, s1_z;
  logic signed [ROT_W-1:0] s2_x, s2_y, s2_z;
  logic signed [TRIG_W-1:0] sxa, cxa, sya, cya, sza, cza;

  assign sxa = $signed(trig.sin_x);
  assign cxa = $signed(trig.cos_x);
  assign sya = $signed(trig.sin_y);
  assign cya = $signed(trig.cos_y);
  assign sza = $signed(trig.sin_z);
  assign cza = $signed(trig.cos_z);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_x <= ROT_W'(vx);
      s1_y <= rnd(mac2(ROT_W'(vy), cxa, ROT_W'(vz), -sxa));
      s1_z <= rnd(mac2(ROT_W'(vy), sxa, ROT_W'(vz), cxa));
    end
    if (en[1]) begin
      s2_x <= rnd(mac2(s1_x, cya, s1_z, sya));
      s2_y <= s1_y;
      s2_z <= rnd(mac2(s1_z, cya, s1_x, -sya));
    end
    if (en[2]) begin
      x3 <= rnd(mac2(s2_x, cza, s2_y, -sza));
      y3 <= rnd(mac2(s2_x, sza, s2_y, cza));
      z2 <= s2_z;
    end
  end

endmodule
`default_nettype wire

### sv/vrp_divider.sv
// Pipelined signed divide, truncating toward zero, saturated to 16 bits; two quotient bits a stage.
`default_nettype none
module vrp_divider import vrp_pkg::*; (
  input  wire logic                    clk,
  input  wire logic [DIV_STAGES-1:0]   en,
  input  wire logic signed [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0]        den,
  output logic signed [COORD_W-1:0]    quot
);

  logic [MAG_W-1:0]  rem_q  [0:DIV_STEPS];
  logic [QUOT_W-1:0] part_q [0:DIV_STEPS];
  logic [DEN_W-1:0]  den_q  [0:DIV_STEPS];
  logic              neg_q  [0:DIV_STEPS];
  logic              ovf_q  [0:DIV_STEPS];
  logic [MAG_W-1:0]  mag;
  logic signed [COORD_W-1:0] sat_w;

  assign mag = num[NUM_W-1] ? MAG_W'(-num) : MAG_W'(num);

  // quotient that needs more than QUOT_W bits saturates anyway
  always_ff @(posedge clk) begin
    if (en[0]) begin
      rem_q[0]  <= mag;
      part_q[0] <= '0;
      den_q[0]  <= den;
      neg_q[0]  <= num[NUM_W-1];
      ovf_q[0]  <= DEN_W'(mag >> QUOT_W) >= den;
    end
  end

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
    logic [MAG_W-1:0]  rem_w;
    logic [QUOT_W-1:0] part_w;
    logic [CMP_W-1:0]  sub_w;

    always_comb begin
      int pos;
      rem_w  = rem_q[j];
      part_w = part_q[j];
      sub_w  = '0;
      for (int b = 0; b < STEP_BITS; b++) begin
        pos = QUOT_W - 1 - j * STEP_BITS - b;
        if (pos >= 0) begin
          sub_w = CMP_W'(den_q[j]) << pos;
          if (CMP_W'(rem_w) >= sub_w) begin
            rem_w  = MAG_W'(CMP_W'(rem_w) - sub_w);
            part_w = part_w | (QUOT_W'(1) << pos);
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en[j+1]) begin
        rem_q[j+1]  <= rem_w;
        part_q[j+1] <= part_w;
        den_q[j+1]  <= den_q[j];
        neg_q[j+1]  <= neg_q[j];
        ovf_q[j+1]  <= ovf_q[j];
      end
    end
  end

  always_comb begin
    if (neg_q[DIV_STEPS]) begin
      if (ovf_q[DIV_STEPS] || part_q[DIV_STEPS] > NEG_LIMIT) sat_w = OUT_MIN;
      else sat_w = COORD_W'(QUOT_W'(0) - part_q[DIV_STEPS]);
    end else begin
      if (ovf_q[DIV_STEPS] || part_q[DIV_STEPS] > POS_LIMIT) sat_w = OUT_MAX;
      else sat_w = COORD_W'(part_q[DIV_STEPS]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[DIV_STAGES-1]) quot <= sat_w;
  end

endmodule
`default_nettype wire

### verif/vertex_rotate_project_checker.sv
// Checker: predicts rotated and projected vertices and compares them with the output transfers.
`timescale 1ns / 1ps
`default_nettype none
module vertex_rotate_project_checker import vrp_pkg::*; (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  input  wire logic                      in_ready,
  input  wire logic signed [COORD_W-1:0] vertex_x,
  input  wire logic signed [COORD_W-1:0] vertex_y,
  input  wire logic signed [COORD_W-1:0] vertex_z,
  input  wire logic                      out_valid,
  input  wire logic                      out_ready,
  input  wire logic signed [COORD_W-1:0] screen_x,
  input  wire logic signed [COORD_W-1:0] screen_y,
  input  wire logic                      behind_viewer,
  input  wire logic                      cfg_valid,
  input  wire logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [CFG_DATA_W-1:0]     cfg_data,
  output int                             fail_count,
  output int                             pending
);

  typedef struct packed {
    logic signed [COORD_W-1:0] sx;
    logic signed [COORD_W-1:0] sy;
    logic                      behind;
  } pixel_t;

  pixel_t pixel_q[$];

  logic [ANGLE_W-1:0]  ax, ay, az;
  logic [DIST_W-1:0]   view_dist;
  logic [FOCAL_W-1:0]  focal;
  logic [CENTER_W-1:0] cx, cy;

  // quarter-wave sine table, Q12, 1025 entries
  longint sin_tab [0:SINE_TABLE_ENTRIES];

  initial begin
    longint unsigned t, x, x2, r;
    longint s;
    for (int i = 0; i <= SINE_TABLE_ENTRIES; i++) begin
      x  = longint'(i) * 64'd1686629713 / 1024;
      x2 = (x * x) >> 30;
      t  = x;
      s  = longint'(x);
      for (int k = 1; k <= 7; k++) begin
        t = ((t * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
        s = (k % 2) ? s - longint'(t) : s + longint'(t);
      end
      if (s < 0) s = 0;
      r = (longint'(s) + 64'd131072) >> 18;
      if (r > 4096) r = 4096;
      sin_tab[i] = longint'(r);
    end
  end

  function automatic longint sine(input int unsigned a);
    int unsigned q, ph;
    longint v;
    a  = a & 4095;
    q  = a >> 10;
    ph = a & 1023;
    if (q & 1) ph = 1024 - ph;
    v = sin_tab[ph];
    return (q & 2) ? -v : v;
  endfunction

  function automatic longint rnd12(input longint v);
    longint w;
    w = v + 2048;
    if (w >= 0) return w >>> 12;
    return -((-w + 4095) >>> 12);
  endfunction

  function automatic longint clip16(input longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic pixel_t project_vertex(input longint x, input longint y, input longint z);
    longint cxa, sxa, cya, sya, cza, sza, y1, z1, x2, z2, x3, y3, d, f;
    pixel_t p;
    cxa = sine(ax + 1024); sxa = sine(ax);
    cya = sine(ay + 1024); sya = sine(ay);
    cza = sine(az + 1024); sza = sine(az);
    y1 = rnd12(y * cxa - z * sxa);
    z1 = rnd12(y * sxa + z * cxa);
    x2 = rnd12(x * cya + z1 * sya);
    z2 = rnd12(z1 * cya - x * sya);
    x3 = rnd12(x2 * cza - y1 * sza);
    y3 = rnd12(x2 * sza + y1 * cza);
    d  = z2 + longint'(view_dist);
    if (d <= 0) begin
      p = '{sx: '0, sy: '0, behind: 1'b1};
    end else begin
      f = longint'(focal);
      // SV division truncates toward zero, as required
      p.sx = COORD_W'(clip16((longint'(cx) * d + x3 * f) / d));
      p.sy = COORD_W'(clip16((longint'(cy) * 2 * d - y3 * f) / (2 * d)));
      p.behind = 1'b0;
    end
    return p;
  endfunction

  task automatic report(input string what);
    $display("mismatch at %0t: %s", $time, what);
    fail_count++;
  endtask

  assign pending = pixel_q.size();

  initial fail_count = 0;

  always @(posedge clk) begin
    pixel_t e;
    if (rst) begin
      ax <= '0; ay <= '0; az <= '0;
      view_dist <= DIST_RESET; focal <= FOCAL_RESET; cx <= CX_RESET; cy <= CY_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ANGLE_X:       ax <= cfg_data[ANGLE_W-1:0];
          REG_ANGLE_Y:       ay <= cfg_data[ANGLE_W-1:0];
          REG_ANGLE_Z:       az <= cfg_data[ANGLE_W-1:0];
          REG_VIEW_DISTANCE: view_dist <= cfg_data[DIST_W-1:0];
          REG_FOCAL_SCALE:   focal <= cfg_data[FOCAL_W-1:0];
          REG_CENTER_X:      cx <= cfg_data[CENTER_W-1:0];
          REG_CENTER_Y:      cy <= cfg_data[CENTER_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        pixel_q.push_back(project_vertex(vertex_x, vertex_y, vertex_z));
      if (out_valid && out_ready) begin
        if (pixel_q.size() == 0) begin
          report("result with nothing expected");
        end else begin
          e = pixel_q.pop_front();
          if (screen_x !== e.sx)
            report($sformatf("screen_x %0d, want %0d", screen_x, e.sx));
          if (screen_y !== e.sy)
            report($sformatf("screen_y %0d, want %0d", screen_y, e.sy));
          if (behind_viewer !== e.behind)
            report($sformatf("behind_viewer %0b, want %0b", behind_viewer, e.behind));
        end
      end
    end
  end

endmodule
`default_nettype wire

### verif/tb_vertex_rotate_project.sv
// Testbench top: stimulus, configuration phases, back-pressure and the verdict.
`timescale 1ns / 1ps
`default_nettype none
module tb_vertex_rotate_project import vrp_pkg::*; ();

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0, in_ready;
  logic signed [COORD_W-1:0] vertex_x = '0, vertex_y = '0, vertex_z = '0;
  logic out_valid, out_ready = 1'b0;
  logic signed [COORD_W-1:0] screen_x, screen_y;
  logic behind_viewer;
  logic cfg_valid = 1'b0, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int fail_count, pending;
  int cycle = 0;
  bit hold_off = 1'b0;

  localparam int CYCLE_LIMIT = 400000;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  vertex_rotate_project dut (.*);

  vertex_rotate_project_checker chk (.*);

  always @(posedge clk) begin
    cycle++;
    if (cycle > CYCLE_LIMIT) begin
      $display("timeout");
      $display("tb_vertex_rotate_project NOT OK");
      $finish;
    end
  end

  // receiver: own stall pattern, with a long hold-off when asked
  always @(negedge clk) begin
    if (rst || hold_off) out_ready <= 1'b0;
    else if (cycle % 600 < 150) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(0, 3) != 0);
  end

  // cfg_valid drops after each write, which keeps back-to-back writes apart
  task automatic write_reg(input cfg_reg_t idx, input int unsigned val);
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(val);
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_vertex(input int x, input int y, input int z);
    vertex_x <= COORD_W'(x);
    vertex_y <= COORD_W'(y);
    vertex_z <= COORD_W'(z);
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  function automatic int rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 32767 : -32768;
      1, 2: return int'($urandom_range(0, 8192)) - 4096;
      default: return int'($urandom_range(0, 65535)) - 32768;
    endcase
  endfunction

  // random bursts with random gaps
  task automatic random_vertices(input int n);
    int burst;
    int gap;
    burst = 0;
    for (int i = 0; i < n; i++) begin
      if (burst == 0) begin
        gap = $urandom_range(0, 4);
        if (gap != 0) in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
        burst = $urandom_range(1, 30);
      end
      burst--;
      send_vertex(rand_coord(), rand_coord(), rand_coord());
    end
  endtask

  initial begin
    int ext [4];
    ext = '{-32768, 32767, 0, -1};
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: field extremes, z + distance at and around zero
    foreach (ext[i]) send_vertex(ext[i], ext[(i + 1) % 4], ext[(i + 2) % 4]);
    send_vertex(4096, 4096, -20480);
    send_vertex(4096, -4096, -20479);
    send_vertex(-4096, 4096, -20481);
    send_vertex(32767, 32767, -20000);
    send_vertex(-32768, -32768, -20000);
    drain();

    // extreme settings: all angles, zero and max distance and focal
    write_reg(REG_ANGLE_X, 4095);
    write_reg(REG_ANGLE_Y, 1024);
    write_reg(REG_ANGLE_Z, 2048);
    write_reg(REG_VIEW_DISTANCE, 0);
    write_reg(REG_FOCAL_SCALE, 255);
    write_reg(REG_CENTER_X, 1023);
    write_reg(REG_CENTER_Y, 0);
    foreach (ext[i]) send_vertex(ext[(i + 3) % 4], ext[i], ext[(i + 1) % 4]);
    send_vertex(0, 0, 1);
    drain();
    write_reg(REG_VIEW_DISTANCE, 32767);
    write_reg(REG_FOCAL_SCALE, 0);
    write_reg(REG_CENTER_X, 0);
    write_reg(REG_CENTER_Y, 1023);
    foreach (ext[i]) send_vertex(ext[i], ext[(i + 2) % 4], ext[(i + 3) % 4]);
    drain();

    // long receiver hold-off while the sender keeps offering
    write_reg(REG_FOCAL_SCALE, 1);
    fork
      begin
        hold_off = 1'b1;
        repeat (200) @(negedge clk);
        hold_off = 1'b0;
      end
      random_vertices(60);
    join
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      write_reg(REG_ANGLE_X, $urandom_range(0, 4095));
      write_reg(REG_ANGLE_Y, $urandom_range(0, 4095));
      write_reg(REG_ANGLE_Z, $urandom_range(0, 4095));
      write_reg(REG_VIEW_DISTANCE, (ph % 2) ? $urandom_range(1, 32767) : 20480);
      write_reg(REG_FOCAL_SCALE, $urandom_range(1, 255));
      write_reg(REG_CENTER_X, $urandom_range(0, 1023));
      write_reg(REG_CENTER_Y, $urandom_range(0, 1023));
      random_vertices(180);
      drain();
    end

    if (fail_count == 0) $display("tb_vertex_rotate_project OK");
    else $display("tb_vertex_rotate_project NOT OK");
    $finish;
  end

endmodule
`default_nettype wire
